/* src/dwtc_pkg.sv */
// ----------------------------------------------------------------------------
// dwtc_pkg: shared constants and types for the decimal formatter
// Widths of the binary operand and of the packed BCD word, ASCII codes and
// the record that carries a finished conversion to the character sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dwtc_pkg;

  // Width of the number that is formatted; upper input bits are ignored.
  localparam int unsigned VALUE_BITS = 64;
  // Decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 0.30103).
  localparam int unsigned DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_BITS   = DIGITS * 4;
  localparam int unsigned IDX_BITS   = $clog2(DIGITS);
  localparam int unsigned CNT_BITS   = $clog2(VALUE_BITS);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam int unsigned GROUP_DIGITS = 3;
  localparam logic [3:0] ADJ_LIMIT   = 4'd5;
  localparam logic [3:0] ADJ_ADD     = 4'd3;

  typedef logic [BCD_BITS-1:0] bcd_t;
  typedef logic [IDX_BITS-1:0] idx_t;

  typedef struct packed {
    logic done;
    bcd_t bcd;
  } conv_res_t;

  // Remainder of a digit index by the group size.
  function automatic idx_t idx_mod_group(input idx_t v);
    idx_t r;
    r = v;
    for (int k = 0; k < 7; k++) begin
      if (r >= idx_t'(GROUP_DIGITS)) begin
        r = r - idx_t'(GROUP_DIGITS);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/dwtc_bcd_conv.sv */
// ----------------------------------------------------------------------------
// dwtc_bcd_conv: iterative binary to BCD converter
// Shift-and-add-3 conversion, one binary bit per cycle through one shared
// digit adjust stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dwtc_bcd_conv (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [dwtc_pkg::VALUE_BITS-1:0]     value_i,
  output dwtc_pkg::conv_res_t                      res_o,
  output logic                                     busy_o
);

  logic                                 busy_q, busy_d;
  logic                                 done_q, done_d;
  logic [dwtc_pkg::CNT_BITS-1:0]        cnt_q, cnt_d;
  logic [dwtc_pkg::VALUE_BITS-1:0]      bin_q, bin_d;
  dwtc_pkg::bcd_t                       bcd_q, bcd_d;
  dwtc_pkg::bcd_t                       adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < dwtc_pkg::DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= dwtc_pkg::ADJ_LIMIT) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + dwtc_pkg::ADJ_ADD;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[dwtc_pkg::BCD_BITS-2:0], bin_q[dwtc_pkg::VALUE_BITS-1]};
      bin_d = {bin_q[dwtc_pkg::VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dwtc_pkg::CNT_BITS'(dwtc_pkg::VALUE_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done = done_q;
  assign res_o.bcd  = bcd_q;
  assign busy_o     = busy_q | done_q;

endmodule

`default_nettype wire

/* src/dwtc_emit.sv */
// ----------------------------------------------------------------------------
// dwtc_emit: character sequencer
// Walks the BCD digits from the most significant nonzero one down, inserts
// a comma at each group boundary and holds the output item in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwtc_emit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dwtc_pkg::conv_res_t  res_i,
  output logic                      busy_o,
  output logic                      tvalid_o,
  input  wire logic                 tready_i,
  output logic [7:0]                tdata_o,
  output logic                      tlast_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIGIT = 2'd1;
  localparam logic [1:0] ST_COMMA = 2'd2;

  logic [1:0]       state_q, state_d;
  dwtc_pkg::bcd_t   bcd_q, bcd_d;
  dwtc_pkg::idx_t   idx_q, idx_d;
  logic [1:0]       grp_q, grp_d;
  logic             vld_q, vld_d;
  logic [7:0]       chr_q, chr_d;
  logic             lst_q, lst_d;
  dwtc_pkg::idx_t   top_idx;
  logic [3:0]       cur_digit;
  logic             advance;

  // Most significant nonzero digit; zero gives index 0.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < dwtc_pkg::DIGITS; i++) begin
      if (res_i.bcd[i*4 +: 4] != 4'd0) begin
        top_idx = dwtc_pkg::idx_t'(i);
      end
    end
  end

  assign cur_digit = bcd_q[idx_q*4 +: 4];
  assign advance   = !vld_q || tready_i;

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    idx_d   = idx_q;
    grp_d   = grp_q;
    vld_d   = vld_q && !tready_i;
    chr_d   = chr_q;
    lst_d   = lst_q;
    unique case (state_q)
      ST_IDLE: begin
        if (res_i.done) begin
          state_d = ST_DIGIT;
          bcd_d   = res_i.bcd;
          idx_d   = top_idx;
          grp_d   = 2'(dwtc_pkg::idx_mod_group(top_idx)) + 2'd1;
        end
      end
      ST_DIGIT: begin
        if (advance) begin
          vld_d = 1'b1;
          chr_d = dwtc_pkg::ASCII_ZERO | {4'd0, cur_digit};
          lst_d = (idx_q == '0);
          idx_d = idx_q - 1'b1;
          grp_d = grp_q - 2'd1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else if (grp_q == 2'd1) begin
            state_d = ST_COMMA;
            grp_d   = 2'(dwtc_pkg::GROUP_DIGITS);
          end
        end
      end
      ST_COMMA: begin
        if (advance) begin
          vld_d   = 1'b1;
          chr_d   = dwtc_pkg::ASCII_COMMA;
          lst_d   = 1'b0;
          state_d = ST_DIGIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    idx_q <= idx_d;
    grp_q <= grp_d;
    chr_q <= chr_d;
    lst_q <= lst_d;
  end

  assign busy_o   = (state_q != ST_IDLE) || vld_q;
  assign tvalid_o = vld_q;
  assign tdata_o  = chr_q;
  assign tlast_o  = lst_q;

endmodule

`default_nettype wire

/* src/decimal_with_thousands_commas.sv */
// ----------------------------------------------------------------------------
// decimal_with_thousands_commas: binary to decimal ASCII with separators
// Formats an unsigned number as decimal text, most significant character
// first, with a comma between each group of three digits.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                               End marker
//  s_axis    in   tdata[63:0] value                     -
//  m_axis    out  tdata[7:0] character                  tlast = last character
//
// An accepted item is shifted through the shift-and-add-3 converter, all
// VALUE_BITS (64) bits of it; then the leading digit is located, and the
// characters (1 to 26) are sent, one per cycle when the sink is ready.
// The single digit adjust stage inside the converter sets its pace.
// s_axis_tready is high only when the converter, the sequencer and the
// output register are all empty. A stalled sink holds the output register
// and the sequencer; nothing is lost. Reset clears all control state; there
// is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_with_thousands_commas (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] character
  output logic             m_axis_tlast    // last character of the number
);

  dwtc_pkg::conv_res_t conv_res;
  logic                conv_busy;
  logic                emit_busy;
  logic                in_accept;

  // The block holds one number at a time: it takes a new item only when the
  // converter and the character path have both drained.
  assign s_axis_tready = !conv_busy && !emit_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Only the low VALUE_BITS bits of the value are formatted.
  dwtc_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .value_i (s_axis_tdata[dwtc_pkg::VALUE_BITS-1:0]),
    .res_o   (conv_res),
    .busy_o  (conv_busy)
  );

  // The sequencer turns the BCD word into characters and commas.
  dwtc_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (conv_res),
    .busy_o   (emit_busy),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // Once a number is taken, the input side closes in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("input ready while a number is in work");

  // A comma never closes the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata == dwtc_pkg::ASCII_COMMA) |-> !m_axis_tlast)
    else $error("comma flagged as last character");

  // A finished conversion only arrives while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_res.done |-> !emit_busy)
    else $error("conversion finished while characters still pending");

  // The input side is never open while output is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while an output item waits");
`endif

endmodule

`default_nettype wire

/* tb/sv/decimal_with_thousands_commas_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_with_thousands_commas_tb: self-checking bench for the formatter
// Sends 64-bit numbers into the slave stream. The bench builds the expected
// comma-separated decimal text for every accepted number and compares it,
// character by character, with the master stream. Both sides idle at
// random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------

module decimal_with_thousands_commas_tb;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RANDOM_ITEMS  = 200;
  // Room for a full conversion plus the longest text.
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned HOLD_START    = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam longint unsigned CYCLE_LIMIT = 500_000;

  // One expected output character and its end-of-text flag.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  // Holds the decimal text still owed by the block, oldest character first.
  class comma_text_board;
    text_char_t  owed_chars[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Formats an accepted number and queues its characters.
    function void note_value(logic [63:0] raw);
      logic [63:0] num;
      logic [63:0] keep_mask;
      text_char_t  rev[$];
      text_char_t  c;
      int unsigned in_group;
      keep_mask = (dwtc_pkg::VALUE_BITS >= 64) ? '1 :
                  ((64'd1 << dwtc_pkg::VALUE_BITS) - 64'd1);
      num = raw & keep_mask;
      in_group = 0;
      // Build the text from the right; a comma closes each full group only
      // when more digits remain, so none can lead or trail.
      do begin
        c.character = dwtc_pkg::ASCII_ZERO + 8'(num % 64'd10);
        c.last = 1'b0;
        rev = {rev, c};
        num = num / 64'd10;
        in_group++;
        if (in_group == dwtc_pkg::GROUP_DIGITS && num != 64'd0) begin
          c.character = dwtc_pkg::ASCII_COMMA;
          rev = {rev, c};
          in_group = 0;
        end
      end while (num != 64'd0);
      for (int k = rev.size() - 1; k >= 0; k--) begin
        c = rev[k];
        c.last = (k == 0);
        owed_chars = {owed_chars, c};
      end
    endfunction

    // Compares one received character with the oldest one owed.
    function void check_char(logic [7:0] ch, logic last_flag);
      text_char_t want;
      if (owed_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h last %b",
                 $time, ch, last_flag);
        errors++;
        return;
      end
      want = owed_chars.pop_front();
      if (ch !== want.character) begin
        $display("%0t: character mismatch, expected %h, got %h",
                 $time, want.character, ch);
        errors++;
      end
      if (last_flag !== want.last) begin
        $display("%0t: last flag mismatch, expected %b, got %b",
                 $time, want.last, last_flag);
        errors++;
      end
    endfunction

    function int unsigned owed();
      return owed_chars.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  comma_text_board board;

  // The sender and the sink each switch between idling and back-to-back runs.
  bit          send_quiet;
  bit          sink_quiet;
  // Raised for one long stretch so the block fills and blocks its input.
  bit          sink_hold;
  longint unsigned cycle_count;

  decimal_with_thousands_commas dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #CLK_HALF clk_i = ~clk_i;
    end
  end

  // Cycle watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one number after a random gap and waits until it is taken.
  task automatic send_value(input logic [63:0] v);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_value(v);
    @(negedge clk_i);
  endtask

  // Ten to the power k, for k up to 19 (the largest that fits 64 bits).
  function automatic logic [63:0] pow10(input int unsigned k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Random numbers spread over every length of text. Most draws pick a
  // random width so that short and long texts both appear often; some sit
  // right at a power of ten, where a new digit or group starts.
  function automatic logic [63:0] random_value();
    int unsigned mode;
    int unsigned width;
    logic [63:0] v;
    mode = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    if (mode <= 1) begin
      v = pow10($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
    end else if (mode <= 7) begin
      width = $urandom_range(1, 64);
      if (width < 64) begin
        v = v & ((64'd1 << width) - 64'd1);
      end
    end
    return v;
  endfunction

  // Sink: draws a gap before each character and honors the long hold-off.
  initial begin
    int unsigned gap;
    int unsigned taken;
    m_axis_tready = 1'b0;
    sink_quiet = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0 || sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
        while (sink_hold) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_char(m_axis_tdata, m_axis_tlast);
      taken++;
      if (taken % 60 == 0) begin
        sink_quiet = ($urandom_range(0, 2) == 0);
      end
      @(negedge clk_i);
    end
  end

  // Long sink hold-off, timed in its own process on the rising edge so it
  // never races the sink's falling-edge decisions.
  initial begin
    sink_hold = 1'b0;
    @(posedge rst_ni);
    repeat (HOLD_START) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    logic [63:0] directed_values[$];
    board = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_quiet    = 1'b0;

    // Extremes, zero, and several points where the leading group changes size
    // or a new comma appears.
    directed_values = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd999, 64'd1000,
      64'd9999, 64'd12345, 64'd100000, 64'd999999, 64'd1000000,
      64'd1234567, 64'd1000000000, 64'd999999999999,
      64'd1000000000000000000, 64'd9999999999999999999,
      64'd10000000000000000000, 64'h8000_0000_0000_0000,
      64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF
    };

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) begin
        send_quiet = ($urandom_range(0, 2) == 0);
      end
      send_value(random_value());
    end
    s_axis_tvalid <= 1'b0;

    // Wait for every owed character, then give the block time to show
    // anything extra it might still emit.
    while (board.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* decimal_with_thousands_commas.f */
src/dwtc_pkg.sv
src/dwtc_bcd_conv.sv
src/dwtc_emit.sv
src/decimal_with_thousands_commas.sv
tb/sv/decimal_with_thousands_commas_tb.sv
